### src/message_deframer_macros.svh
// ----------------------------------------------------------------------------
// message_deframer assertion macros
// Shared wrappers for the concurrent checks of the deframer modules. Each use
// expects signals named clk and rst_n in the module that includes this file.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_DEFRAMER_MACROS_SVH
`define MESSAGE_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mdf_pkg.sv
// ----------------------------------------------------------------------------
// mdf_pkg
// Types and constants shared by the message deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mdf_pkg;

  localparam int BYTE_W = 8;

  // frame_mode codes
  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_LEN   = 2'd1;
  localparam logic [1:0] MODE_DELIM = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;

  // Header byte count; reaching it means the payload phase is active.
  localparam logic [2:0] HDR_BYTES = 3'd4;
  // Depth of the delimiter look-behind window.
  localparam logic [1:0] HOLD_FULL = 2'd3;

  // One result word handed from the deframing core to the output stage.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              has_data;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### src/mdf_core.sv
// ----------------------------------------------------------------------------
// mdf_core
// Deframing state and per-word decode: raw, length, delimiter and off modes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "message_deframer_macros.svh"

module mdf_core
  import mdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_mode,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic              chunk_end,
  output res_t                   res
);

  logic [1:0]        mode_r, mode_nxt;
  logic [BYTE_W-1:0] held_r   [3];
  logic [BYTE_W-1:0] held_nxt [3];
  logic [1:0]        held_cnt_r, held_cnt_nxt;
  logic [2:0]        hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       len_ins;
  logic              delim_hit;

  // Header value with the current byte merged into its lane.
  always_comb begin
    len_ins = len_r;
    for (int i = 0; i < 4; i++) begin
      if (hdr_cnt_r[1:0] == 2'(i)) begin
        len_ins[8*i +: 8] = len_r[8*i +: 8] | rx_byte;
      end
    end
  end

  assign delim_hit = (held_r[0] == CR_BYTE) && (held_r[1] == LF_BYTE) &&
                     (held_r[2] == CR_BYTE) && (rx_byte == LF_BYTE);

  always_comb begin
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    res          = '0;

    if (cfg_we) begin
      // A mode write restarts on a message boundary.
      mode_nxt     = cfg_mode;
      held_nxt[0]  = '0;
      held_nxt[1]  = '0;
      held_nxt[2]  = '0;
      held_cnt_nxt = '0;
      hdr_cnt_nxt  = '0;
      len_nxt      = '0;
      rem_nxt      = '0;
    end else if (accept) begin
      unique case (mode_r)
        MODE_RAW: begin
          res.valid        = 1'b1;
          res.payload_byte = rx_byte;
          res.has_data     = 1'b1;
          res.last         = chunk_end;
        end
        MODE_LEN: begin
          if (hdr_cnt_r != HDR_BYTES) begin
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
            len_nxt     = len_ins;
            if (hdr_cnt_r == HDR_BYTES - 3'd1) begin
              len_nxt = '0;
              if (len_ins == '0) begin
                // Empty message: end marker only, next byte opens a header.
                hdr_cnt_nxt = '0;
                res.valid   = 1'b1;
                res.last    = 1'b1;
              end else begin
                rem_nxt = len_ins;
              end
            end
          end else begin
            rem_nxt          = rem_r - 32'd1;
            res.valid        = 1'b1;
            res.payload_byte = rx_byte;
            res.has_data     = 1'b1;
            if (rem_r == 32'd1) begin
              res.last    = 1'b1;
              hdr_cnt_nxt = '0;
              len_nxt     = '0;
            end
          end
        end
        MODE_DELIM: begin
          if (held_cnt_r != HOLD_FULL) begin
            held_nxt[held_cnt_r] = rx_byte;
            held_cnt_nxt         = held_cnt_r + 2'd1;
          end else if (delim_hit) begin
            held_nxt[0]  = '0;
            held_nxt[1]  = '0;
            held_nxt[2]  = '0;
            held_cnt_nxt = '0;
            res.valid    = 1'b1;
            res.last     = 1'b1;
          end else begin
            res.valid        = 1'b1;
            res.payload_byte = held_r[0];
            res.has_data     = 1'b1;
            held_nxt[0]      = held_r[1];
            held_nxt[1]      = held_r[2];
            held_nxt[2]      = rx_byte;
          end
        end
        MODE_OFF: begin
          // Words are dropped and the state is kept.
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RAW;
      held_r[0]  <= '0;
      held_r[1]  <= '0;
      held_r[2]  <= '0;
      held_cnt_r <= '0;
      hdr_cnt_r  <= '0;
      len_r      <= '0;
      rem_r      <= '0;
    end else begin
      mode_r     <= mode_nxt;
      held_r     <= held_nxt;
      held_cnt_r <= held_cnt_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      len_r      <= len_nxt;
      rem_r      <= rem_nxt;
    end
  end

  `MDF_ASSERT_IMP(a_hdr_cnt_range, 1'b1, hdr_cnt_r <= HDR_BYTES,
                  "header count ran past the header length")
  `MDF_ASSERT_IMP(a_payload_rem_nonzero, hdr_cnt_r == HDR_BYTES, rem_r != 32'd0,
                  "payload phase active with no bytes remaining")
  `MDF_ASSERT_IMP(a_held_cnt_range, 1'b1, held_cnt_r <= HOLD_FULL,
                  "delimiter window count ran past the window depth")

endmodule

`default_nettype wire

### src/mdf_skid.sv
// ----------------------------------------------------------------------------
// mdf_skid
// Result register with a one-word skid stage, so the core can accept one
// more word after the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "message_deframer_macros.svh"

module mdf_skid
  import mdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire res_t              push,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_payload,
  output logic                   out_has_data,
  output logic                   out_last
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic drain;

  assign drain = !main_valid_r || out_ready;
  assign ready = !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (drain) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push;
        main_valid_nxt = push.valid;
      end
    end else if (push.valid) begin
      skid_nxt       = push;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid    = main_valid_r;
  assign out_payload  = main_r.payload_byte;
  assign out_has_data = main_r.has_data;
  assign out_last     = main_r.last;

  `MDF_ASSERT_IMP(a_skid_implies_main, skid_valid_r, main_valid_r,
                  "skid word held while the result register is empty")
  `MDF_ASSERT_IMP(a_no_push_when_full, push.valid, !skid_valid_r,
                  "result pushed while the skid stage is occupied")
  `MDF_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_valid_r),
                  $past(main_valid_r && !out_ready),
                  "skid stage filled without a receiver stall")

endmodule

`default_nettype wire

### src/message_deframer.sv
// ----------------------------------------------------------------------------
// message_deframer
// Byte-stream deframer: raw chunks, length-prefixed or CR LF CR LF framing.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one received byte per word in in_tdata, with
//   in_tlast marking the end of a readable chunk (used in raw mode only).
//   The out_ stream carries one result word: out_tdata holds the payload
//   byte, out_tuser is set when that byte is real payload (clear for an
//   end-of-message marker), and out_tlast ends the current message.
//   The cfg_ stream writes frame_mode (0 raw, 1 four-byte little-endian
//   length header, 2 CR LF CR LF delimited, 3 drop all bytes); a write also
//   clears all framing state. Write it only while the block is idle.
//   Each result passes through the result register (or the skid stage, on a
//   stall) to the out_ stream. Throughput: one byte per cycle while in_tready
//   is high, set by the core's state update followed by the result register.
//   Header bytes and the first three bytes held in the delimiter window
//   produce no result word, apart from the end marker of an empty message.
//   Reset (synchronous, active low) selects raw mode and clears all state.
//   When the receiver stalls, one further result is caught in a skid stage;
//   in_tready then drops until the result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module message_deframer
  import mdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,    // [1:0] frame_mode
  // Input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  wire logic        in_tlast,    // chunk_end
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] payload_byte
  output logic             out_tuser,   // [0] has_data
  output logic             out_tlast    // last
);

  logic cfg_we;
  logic accept;
  res_t res;

  // Register writes are always taken; user must write them only while idle.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = in_tvalid && in_tready;

  mdf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_mode  (cfg_data),
    .accept    (accept),
    .rx_byte   (in_tdata),
    .chunk_end (in_tlast),
    .res       (res)
  );

  mdf_skid u_skid (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (res),
    .ready        (in_tready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_payload  (out_tdata),
    .out_has_data (out_tuser),
    .out_last     (out_tlast)
  );

endmodule

`default_nettype wire
